### hw/rtl/assert_macros.svh
//------------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the sparse matvec block.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SMV_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define SMV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// delayed implication
`define SMV_ASSERT_LATER2(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("assertion failed: two-cycle implication");

`endif

### hw/rtl/smv_pkg.sv
//------------------------------------------------------------------------------
// smv_pkg
// Shared types and constants of the compressed-row sparse matvec block.
//------------------------------------------------------------------------------
package smv_pkg;

   localparam int unsigned VECTOR_DEPTH   = 4096;
   localparam int unsigned VEC_ADDR_BITS  = $clog2(VECTOR_DEPTH);
   localparam int unsigned ROW_INDEX_BITS = 16;

   localparam int unsigned DATA_BITS      = 32;
   localparam int unsigned INDEX_BITS     = 12;
   localparam int unsigned ROW_NUM_BITS   = 16;
   localparam int unsigned REQ_DATA_BITS  = 120;
   localparam int unsigned RSP_DATA_BITS  = 48;
   localparam int unsigned CSR_ADDR_BITS  = 1;

   typedef enum logic [1:0] {
      REQ_LOAD    = 2'd0,
      REQ_NONZERO = 2'd1,
      REQ_EMPTY   = 2'd2
   } req_kind_type;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_ACC_MODE = 1'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SCALE    = 1'd1;

   typedef struct packed {
      logic [DATA_BITS-1:0]      sum;
      logic [DATA_BITS-1:0]      prior;
      logic [ROW_INDEX_BITS-1:0] row;
   } row_close_type;

endpackage

### hw/rtl/smv_ram.sv
//------------------------------------------------------------------------------
// smv_ram
// Generic single-port-write, single-port-read RAM with registered read data.
//------------------------------------------------------------------------------
module smv_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/smv_mac.sv
//------------------------------------------------------------------------------
// smv_mac
// Multiply each nonzero by its vector element and accumulate the row sum;
// issue a closed-row record when a row ends.
//------------------------------------------------------------------------------
module smv_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          accept,
   input  smv_pkg::req_kind_type         kind,
   input  logic [smv_pkg::DATA_BITS-1:0] matrix_value,
   input  logic                          col_ok,
   input  logic                          row_last,
   input  logic [smv_pkg::DATA_BITS-1:0] prior_value,
   input  logic [smv_pkg::DATA_BITS-1:0] ram_rdata,
   output logic                          close_valid,
   output smv_pkg::row_close_type        close
);
   import smv_pkg::*;

   logic                      s1_valid_ff, s1_valid_in;
   logic                      s1_nonzero_ff;
   logic                      s1_last_ff;
   logic                      s1_col_ok_ff;
   logic [DATA_BITS-1:0]      s1_mval_ff;
   logic [DATA_BITS-1:0]      s1_prior_ff;

   logic                      s2_valid_ff;
   logic                      s2_nonzero_ff;
   logic                      s2_last_ff;
   logic [DATA_BITS-1:0]      s2_prod_ff, s2_prod_in;
   logic [DATA_BITS-1:0]      s2_prior_ff;

   logic [DATA_BITS-1:0]      row_sum_ff, row_sum_in;
   logic [ROW_INDEX_BITS-1:0] row_counter_ff, row_counter_in;
   logic                      close_valid_ff, close_valid_in;
   row_close_type             close_ff, close_in;

   logic [DATA_BITS-1:0]      sum;
   logic                      closing;

   always_comb begin
      case (kind)
         REQ_NONZERO: s1_valid_in = accept;
         REQ_EMPTY:   s1_valid_in = accept;
         default:     s1_valid_in = 1'b0;
      endcase
   end

   always_comb begin
      s2_prod_in = s1_mval_ff * (s1_col_ok_ff ? ram_rdata : '0);
   end

   always_comb begin
      sum     = row_sum_ff + (s2_nonzero_ff ? s2_prod_ff : '0);
      closing = s2_valid_ff && (!s2_nonzero_ff || s2_last_ff);

      row_sum_in     = row_sum_ff;
      row_counter_in = row_counter_ff;
      if (s2_valid_ff) begin
         row_sum_in = closing ? '0 : sum;
      end
      if (closing) begin
         row_counter_in = row_counter_ff + 1'b1;
      end

      close_valid_in = closing;
      close_in.sum   = sum;
      close_in.prior = s2_prior_ff;
      close_in.row   = row_counter_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         close_valid_ff <= 1'b0;
         row_sum_ff     <= '0;
         row_counter_ff <= '0;
      end else if (advance) begin
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s1_valid_ff;
         close_valid_ff <= close_valid_in;
         row_sum_ff     <= row_sum_in;
         row_counter_ff <= row_counter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_nonzero_ff <= (kind == REQ_NONZERO);
         s1_last_ff    <= row_last;
         s1_col_ok_ff  <= col_ok;
         s1_mval_ff    <= matrix_value;
         s1_prior_ff   <= prior_value;
         s2_nonzero_ff <= s1_nonzero_ff;
         s2_last_ff    <= s1_last_ff;
         s2_prod_ff    <= s2_prod_in;
         s2_prior_ff   <= s1_prior_ff;
         close_ff      <= close_in;
      end
   end

   assign close_valid = close_valid_ff;
   assign close       = close_ff;

endmodule

### hw/rtl/smv_finish.sv
//------------------------------------------------------------------------------
// smv_finish
// In accumulate mode, scale a closed row sum and add the prior value;
// else pass the sum unscaled; hold the finished beat in the output register.
//------------------------------------------------------------------------------
module smv_finish (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             acc_mode,
   input  logic [smv_pkg::DATA_BITS-1:0]    scale,
   input  logic                             close_valid,
   input  smv_pkg::row_close_type           close,
   output logic                             out_valid,
   output logic [smv_pkg::DATA_BITS-1:0]    row_result,
   output logic [smv_pkg::ROW_NUM_BITS-1:0] row_number
);
   import smv_pkg::*;

   logic                      s4_valid_ff;
   logic [DATA_BITS-1:0]      s4_mul_ff, s4_mul_in;
   row_close_type             s4_close_ff;

   logic                      out_valid_ff;
   logic [DATA_BITS-1:0]      result_ff, result_in;
   logic [ROW_NUM_BITS-1:0]   number_ff, number_in;

   always_comb begin
      s4_mul_in = scale * close.sum;
      result_in = acc_mode ? (s4_close_ff.prior + s4_mul_ff) : s4_close_ff.sum;
      number_in = ROW_NUM_BITS'(s4_close_ff.row);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff  <= close_valid;
         out_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_mul_ff   <= s4_mul_in;
         s4_close_ff <= close;
         result_ff   <= result_in;
         number_ff   <= number_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign row_result = result_ff;
   assign row_number = number_ff;

endmodule

### hw/rtl/csr_sparse_matvec_unit.sv
//------------------------------------------------------------------------------
// csr_sparse_matvec_unit
// Compressed-row sparse matrix times dense vector, 32-bit wrapping integer.
//
//   channel  direction  beat content
//   req      in         tuser kind, tlast row end, tdata indexes and values
//   rsp      out        tdata row result and row number
//   csr      in         write enable, register index, write data
//
// One beat enters per cycle while rsp is not stalled; a closed row's result is
// registered in turn by the vector RAM read, the product multiply, the row-sum
// add, the scale multiply and the output register. Reset clears the row sum,
// row counter, mode and scale (to one); the vector RAM holds nothing until
// loaded. A result beat stalled on rsp holds the whole pipeline and req_tready.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module csr_sparse_matvec_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // vec_index[11:0] vec_value[43:12] col_index[55:44] matrix_value[87:56]
   // prior_value[119:88]
   input  logic [smv_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // req_type[1:0]
   input  logic [1:0]                         req_tuser,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // row_result[31:0] row_number[47:32]
   output logic [smv_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                               csr_we,
   input  logic [smv_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [smv_pkg::DATA_BITS-1:0]      csr_wdata
);
   import smv_pkg::*;

   logic                      advance;
   logic                      accept;
   req_kind_type              kind;
   logic [INDEX_BITS-1:0]     vec_index;
   logic [DATA_BITS-1:0]      vec_value;
   logic [INDEX_BITS-1:0]     col_index;
   logic [DATA_BITS-1:0]      matrix_value;
   logic [DATA_BITS-1:0]      prior_value;
   logic                      vec_ok;
   logic                      col_ok;
   logic                      ram_we;
   logic                      ram_re;
   logic [DATA_BITS-1:0]      ram_rdata;

   logic                      acc_mode_ff;
   logic [DATA_BITS-1:0]      scale_ff;

   logic                      close_valid;
   row_close_type             close;
   logic [DATA_BITS-1:0]      row_result;
   logic [ROW_NUM_BITS-1:0]   row_number;

   assign kind         = req_kind_type'(req_tuser);
   assign vec_index    = req_tdata[11:0];
   assign vec_value    = req_tdata[43:12];
   assign col_index    = req_tdata[55:44];
   assign matrix_value = req_tdata[87:56];
   assign prior_value  = req_tdata[119:88];

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   assign vec_ok = 32'(vec_index) < VECTOR_DEPTH;
   assign col_ok = 32'(col_index) < VECTOR_DEPTH;
   assign ram_we = accept && (kind == REQ_LOAD) && vec_ok;
   assign ram_re = accept && (kind == REQ_NONZERO);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_mode_ff <= 1'b0;
         scale_ff    <= DATA_BITS'(1);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_ACC_MODE: acc_mode_ff <= csr_wdata[0];
            CSR_SCALE:    scale_ff    <= csr_wdata;
            default:      ;
         endcase
      end
   end

   smv_ram #(
      .WIDTH (DATA_BITS),
      .DEPTH (VECTOR_DEPTH)
   ) u_vec_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (vec_index[VEC_ADDR_BITS-1:0]),
      .wdata (vec_value),
      .re    (ram_re),
      .raddr (col_index[VEC_ADDR_BITS-1:0]),
      .rdata (ram_rdata)
   );

   smv_mac u_mac (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .accept       (accept),
      .kind         (kind),
      .matrix_value (matrix_value),
      .col_ok       (col_ok),
      .row_last     (req_tlast),
      .prior_value  (prior_value),
      .ram_rdata    (ram_rdata),
      .close_valid  (close_valid),
      .close        (close)
   );

   smv_finish u_finish (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .acc_mode    (acc_mode_ff),
      .scale       (scale_ff),
      .close_valid (close_valid),
      .close       (close),
      .out_valid   (rsp_tvalid),
      .row_result  (row_result),
      .row_number  (row_number)
   );

   assign rsp_tdata = {row_number, row_result};

   `SMV_ASSERT_IMPLY(a_stall_holds_input, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   `SMV_ASSERT_NEXT(a_reset_clears_output, clock, 1'b0, reset, !rsp_tvalid)
   `SMV_ASSERT_LATER2(a_close_reaches_output, clock, reset, close_valid && advance, rsp_tvalid)

endmodule
